>>> hw/rtl/raster_local_peak_detector_assert.svh
// Assertion macros for the raster local peak detector; empty under synthesis.
`ifndef RASTER_LOCAL_PEAK_DETECTOR_ASSERT_SVH
`define RASTER_LOCAL_PEAK_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define RLPD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rlpd: same-cycle check failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define RLPD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rlpd: next-cycle check failed");

`else

`define RLPD_ASSERT_IMP(lbl, ante, cons)
`define RLPD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> hw/rtl/rlpd_pkg.sv
// Shared constants, register codes, cell control type and size helper.
package rlpd_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_PIXEL_BITS = 16;

    localparam int PORT_PIXEL_BITS = 16;
    localparam int ROW_BITS        = 10;
    localparam int COL_BITS        = 10;
    localparam int CFG_DATA_BITS   = 11;
    localparam int CFG_INDEX_BITS  = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = CFG_INDEX_BITS'(1);

    localparam int RST_FRAME_WIDTH  = 5;
    localparam int RST_FRAME_HEIGHT = 4;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

    // Last index in use for a size register: zero acts as one, oversize as the maximum.
    function automatic int size_last(input int value, input int maxv);
        int last;
        if (value == 0) begin
            last = 0;
        end else if (value > maxv) begin
            last = maxv - 1;
        end else begin
            last = value - 1;
        end
        return last;
    endfunction

endpackage

>>> hw/rtl/rlpd_line_ram.sv
// One row of the line store: one write port, two registered read ports, write-first.
module rlpd_line_ram #(
    parameter int DEPTH     = rlpd_pkg::DEF_MAX_WIDTH,
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = rlpd_pkg::DEF_PIXEL_BITS
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic [ADDR_BITS-1:0] raddr0,
    input  logic [ADDR_BITS-1:0] raddr1,
    output logic [DATA_BITS-1:0] rdata0,
    output logic [DATA_BITS-1:0] rdata1
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rdata0_reg;
    logic [DATA_BITS-1:0] rdata1_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Forward a same-edge write so a read sees the updated entry.
    always_ff @(posedge aclk) begin
        if (we && (waddr == raddr0)) begin
            rdata0_reg <= wdata;
        end else begin
            rdata0_reg <= mem[raddr0];
        end
        if (we && (waddr == raddr1)) begin
            rdata1_reg <= wdata;
        end else begin
            rdata1_reg <= mem[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

>>> hw/rtl/rlpd_cell.sv
// One chain cell: load its own entry, or take the neighbor's on a shift.
module rlpd_cell #(
    parameter type cell_data_t = logic
) (
    input  logic                aclk,
    input  rlpd_pkg::cell_ctl_t ctl,
    input  cell_data_t          own_in,
    input  cell_data_t          chain_in,
    output cell_data_t          data_out
);

    cell_data_t data_reg;
    cell_data_t data_next;

    always_comb begin
        priority if (ctl.load) begin
            data_next = own_in;
        end else if (ctl.shift) begin
            data_next = chain_in;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

>>> hw/rtl/raster_local_peak_detector.sv
// Top level of the raster local peak detector: counters, line store, cell chains, output.
//
// Raster local peak detector. Pixels of a frame arrive in raster order on the s_ channel,
// one item per pixel; frame_width and frame_height (config indexes 0 and 1, zero acts as
// one, oversize acts as the maximum) set the frame, and writing either restarts the frame
// at row 0, column 0. For every pixel the block emits one verdict item on the m_ channel:
// its row, column and value, is_peak (at least every existing up/down/left/right neighbour
// and strictly above one of them) and frame_done on the frame's last pixel. Verdicts come
// out in raster order except on the last row. Pixel (r-1,c) is decided when pixel (r,c)
// arrives; on the last row each pixel also decides its left neighbour, and the last pixel
// decides itself. Rate: one pixel per clock on every row but the last, unless stalled. On
// the last row each pixel after the first yields two verdicts (three at the last column)
// and the single result port, one verdict per clock, sets the pace. The line store is two
// RAMs of MAX_WIDTH pixels, one per row parity, each read at the current and next column
// every cycle; it needs no clearing pass after reset, since no entry is read before the
// frame has written it. A two-cell chain keeps the last two columns (previous-row and
// current-row pixel); a three-cell chain of result slots drains one verdict a clock while
// the skid stage is empty into an output register with a skid stage behind it.
`include "raster_local_peak_detector_assert.svh"

module raster_local_peak_detector #(
    parameter int MAX_WIDTH  = rlpd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rlpd_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = rlpd_pkg::DEF_PIXEL_BITS
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // configuration writes
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [rlpd_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [rlpd_pkg::CFG_DATA_BITS-1:0]        cfg_wdata,
    // pixel input
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic signed [rlpd_pkg::PORT_PIXEL_BITS-1:0] s_pixel_value,
    // verdict output
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic [rlpd_pkg::ROW_BITS-1:0]             m_pixel_row,
    output logic [rlpd_pkg::COL_BITS-1:0]             m_pixel_col,
    output logic signed [rlpd_pkg::PORT_PIXEL_BITS-1:0] m_peak_value,
    output logic                                      m_is_peak,
    output logic                                      m_frame_done
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int NSLOT = 3;
    localparam int NCOL  = 2;

    typedef logic signed [PIXEL_BITS-1:0] pix_t;

    // One column of history: previous-row pixel and current-row pixel.
    typedef struct packed {
        pix_t prev;
        pix_t cur;
    } col_slice_t;

    typedef struct packed {
        logic [RW-1:0] row;
        logic [CW-1:0] col;
        pix_t          value;
        logic          is_peak;
        logic          done;
    } result_t;

    // Peak rule over the neighbours that exist.
    function automatic logic peak_verdict(
        input pix_t ctr,
        input logic hu, input pix_t u,
        input logic hd, input pix_t d,
        input logic hl, input pix_t l,
        input logic hr, input pix_t r
    );
        logic all_ge;
        logic any_gt;
        all_ge = !((hu && (ctr < u)) || (hd && (ctr < d)) ||
                   (hl && (ctr < l)) || (hr && (ctr < r)));
        any_gt = (hu && (ctr > u)) || (hd && (ctr > d)) ||
                 (hl && (ctr > l)) || (hr && (ctr > r));
        return all_ge && any_gt;
    endfunction

    // ------------------------------------------------------------------
    // Position counters and frame size
    // ------------------------------------------------------------------
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] w_last_reg, w_last_next;
    logic [RW-1:0] h_last_reg, h_last_next;

    logic cfg_wr;
    logic s_acc;
    logic last_row;
    logic last_col;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign s_acc     = s_valid && s_ready;
    assign last_row  = (row_reg == h_last_reg);
    assign last_col  = (col_reg == w_last_reg);

    always_comb begin
        col_next    = col_reg;
        row_next    = row_reg;
        w_last_next = w_last_reg;
        h_last_next = h_last_reg;
        priority if (cfg_wr) begin
            // A size write restarts the frame; other indexes do nothing.
            unique case (cfg_index)
                rlpd_pkg::REG_FRAME_WIDTH: begin
                    w_last_next = CW'(rlpd_pkg::size_last(int'(cfg_wdata), MAX_WIDTH));
                    col_next    = '0;
                    row_next    = '0;
                end
                rlpd_pkg::REG_FRAME_HEIGHT: begin
                    h_last_next = RW'(rlpd_pkg::size_last(int'(cfg_wdata), MAX_HEIGHT));
                    col_next    = '0;
                    row_next    = '0;
                end
                default: begin
                end
            endcase
        end else if (s_acc) begin
            // Advance in raster order; wrap to a new frame after the last pixel.
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : (row_reg + RW'(1));
            end else begin
                col_next = col_reg + CW'(1);
            end
        end else begin
            // Hold position and size while idle.
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            w_last_reg <= CW'(rlpd_pkg::size_last(rlpd_pkg::RST_FRAME_WIDTH, MAX_WIDTH));
            h_last_reg <= RW'(rlpd_pkg::size_last(rlpd_pkg::RST_FRAME_HEIGHT, MAX_HEIGHT));
        end else begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            w_last_reg <= w_last_next;
            h_last_reg <= h_last_next;
        end
    end

    // ------------------------------------------------------------------
    // Line store: one RAM per row parity, read ahead at the next position
    // ------------------------------------------------------------------
    pix_t          pix_in;
    logic [CW-1:0] rd_col_p1;
    pix_t          even_q0, even_q1, odd_q0, odd_q1;
    pix_t          center_px, right_px, up_px;

    assign pix_in    = PIXEL_BITS'(s_pixel_value);
    assign rd_col_p1 = col_next + CW'(1);

    rlpd_line_ram #(
        .DEPTH    (MAX_WIDTH),
        .ADDR_BITS(CW),
        .DATA_BITS(PIXEL_BITS)
    ) u_ram_even (
        .aclk  (aclk),
        .we    (s_acc && !row_reg[0]),
        .waddr (col_reg),
        .wdata (pix_in),
        .raddr0(col_next),
        .raddr1(rd_col_p1),
        .rdata0(even_q0),
        .rdata1(even_q1)
    );

    rlpd_line_ram #(
        .DEPTH    (MAX_WIDTH),
        .ADDR_BITS(CW),
        .DATA_BITS(PIXEL_BITS)
    ) u_ram_odd (
        .aclk  (aclk),
        .we    (s_acc && row_reg[0]),
        .waddr (col_reg),
        .wdata (pix_in),
        .raddr0(col_next),
        .raddr1(rd_col_p1),
        .rdata0(odd_q0),
        .rdata1(odd_q1)
    );

    // Previous row lives in the other parity, two rows back in this one.
    assign center_px = row_reg[0] ? even_q0 : odd_q0;
    assign right_px  = row_reg[0] ? even_q1 : odd_q1;
    assign up_px     = row_reg[0] ? odd_q0  : even_q0;

    // ------------------------------------------------------------------
    // Column history chain: cell 0 is column c-1, cell 1 is column c-2
    // ------------------------------------------------------------------
    col_slice_t          new_slice;
    col_slice_t          win_q [NCOL];
    rlpd_pkg::cell_ctl_t win_ctl;

    assign new_slice = '{prev: center_px, cur: pix_in};
    assign win_ctl   = '{load: 1'b0, shift: s_acc};

    for (genvar k = 0; k < NCOL; k++) begin : g_win
        col_slice_t chain_in;
        if (k == 0) begin : g_head
            assign chain_in = new_slice;
        end else begin : g_body
            assign chain_in = win_q[k-1];
        end
        rlpd_cell #(.cell_data_t(col_slice_t)) u_cell (
            .aclk    (aclk),
            .ctl     (win_ctl),
            .own_in  (new_slice),
            .chain_in(chain_in),
            .data_out(win_q[k])
        );
    end

    // ------------------------------------------------------------------
    // Verdicts caused by this pixel, packed in raster order
    // ------------------------------------------------------------------
    result_t    cand [NSLOT];
    logic       cand_v [NSLOT];
    result_t    packed_slot [NSLOT];
    logic [1:0] n_results;

    always_comb begin
        // pixel above, decided now that its lower neighbour is here
        cand_v[0]        = (row_reg != '0);
        cand[0].row      = row_reg - RW'(1);
        cand[0].col      = col_reg;
        cand[0].value    = center_px;
        cand[0].is_peak  = peak_verdict(center_px,
                                         row_reg > RW'(1), up_px,
                                         1'b1, pix_in,
                                         col_reg != '0, win_q[0].prev,
                                         !last_col, right_px);
        cand[0].done     = 1'b0;
        // last row: left neighbour on this row
        cand_v[1]        = last_row && (col_reg != '0);
        cand[1].row      = row_reg;
        cand[1].col      = col_reg - CW'(1);
        cand[1].value    = win_q[0].cur;
        cand[1].is_peak  = peak_verdict(win_q[0].cur,
                                         row_reg != '0, win_q[0].prev,
                                         1'b0, pix_in,
                                         col_reg > CW'(1), win_q[1].cur,
                                         1'b1, pix_in);
        cand[1].done     = 1'b0;
        // last pixel of the frame decides itself
        cand_v[2]        = last_row && last_col;
        cand[2].row      = row_reg;
        cand[2].col      = col_reg;
        cand[2].value    = pix_in;
        cand[2].is_peak  = peak_verdict(pix_in,
                                         row_reg != '0, center_px,
                                         1'b0, pix_in,
                                         col_reg != '0, win_q[0].cur,
                                         1'b0, pix_in);
        cand[2].done     = 1'b1;
    end

    always_comb begin
        n_results = '0;
        for (int j = 0; j < NSLOT; j++) begin
            packed_slot[j] = cand[j];
        end
        for (int j = 0; j < NSLOT; j++) begin
            if (cand_v[j]) begin
                packed_slot[n_results] = cand[j];
                n_results = n_results + 2'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result slot chain: slot 0 drains toward the output
    // ------------------------------------------------------------------
    result_t             slot_q [NSLOT];
    rlpd_pkg::cell_ctl_t slot_ctl;
    logic [1:0]          wcnt_reg, wcnt_next;
    logic                emit;
    logic                skid_valid_reg;

    assign emit     = (wcnt_reg != '0) && !skid_valid_reg;
    assign slot_ctl = '{load: s_acc, shift: emit};

    // Take a pixel once the slots hold nothing that would be left behind.
    assign s_ready = (wcnt_reg == '0) || ((wcnt_reg == 2'd1) && !skid_valid_reg);

    for (genvar k = 0; k < NSLOT; k++) begin : g_slot
        result_t chain_in;
        if (k == NSLOT - 1) begin : g_tail
            assign chain_in = packed_slot[k];
        end else begin : g_body
            assign chain_in = slot_q[k+1];
        end
        rlpd_cell #(.cell_data_t(result_t)) u_cell (
            .aclk    (aclk),
            .ctl     (slot_ctl),
            .own_in  (packed_slot[k]),
            .chain_in(chain_in),
            .data_out(slot_q[k])
        );
    end

    always_comb begin
        priority if (s_acc) begin
            wcnt_next = n_results;
        end else if (emit) begin
            wcnt_next = wcnt_reg - 2'd1;
        end else begin
            wcnt_next = wcnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcnt_reg <= '0;
        end else begin
            wcnt_reg <= wcnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid stage
    // ------------------------------------------------------------------
    logic    o_valid_reg, o_valid_next;
    logic    skid_valid_next;
    result_t o_reg, o_next;
    result_t skid_reg, skid_next;
    logic    o_free;

    assign o_free = !o_valid_reg || m_ready;

    always_comb begin
        o_valid_next    = o_valid_reg;
        skid_valid_next = skid_valid_reg;
        o_next          = o_reg;
        skid_next       = skid_reg;
        if (o_free) begin
            // Refill from the skid first, then from the slot chain.
            o_valid_next    = skid_valid_reg || emit;
            o_next          = skid_valid_reg ? skid_reg : slot_q[0];
            skid_valid_next = 1'b0;
        end else if (emit) begin
            // Output stalled: hold the item in the skid stage.
            skid_valid_next = 1'b1;
            skid_next       = slot_q[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            o_valid_reg    <= o_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        o_reg    <= o_next;
        skid_reg <= skid_next;
    end

    assign m_valid      = o_valid_reg;
    assign m_pixel_row  = rlpd_pkg::ROW_BITS'(o_reg.row);
    assign m_pixel_col  = rlpd_pkg::COL_BITS'(o_reg.col);
    assign m_peak_value = rlpd_pkg::PORT_PIXEL_BITS'($unsigned(o_reg.value));
    assign m_is_peak    = o_reg.is_peak;
    assign m_frame_done = o_reg.done;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `RLPD_ASSERT_IMP(a_col_in_frame, 1'b1, col_reg <= w_last_reg)
    `RLPD_ASSERT_IMP(a_row_in_frame, 1'b1, row_reg <= h_last_reg)
    `RLPD_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, o_valid_reg)
    `RLPD_ASSERT_NXT(a_one_verdict, s_acc && (row_reg != '0) && !last_row, wcnt_reg == 2'd1)
    `RLPD_ASSERT_NXT(a_three_verdicts,
        s_acc && last_row && last_col && (row_reg != '0) && (col_reg != '0),
        wcnt_reg == 2'd3)

endmodule
